// ===== rtl/hkfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the Hermite keyframe evaluator.
// No dependencies; the top level and hkfe_div import this package.
package hkfe_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_AW    = $clog2(MAX_KEYS);
  localparam int FRAC_BITS = 16;
  localparam int UFRAC     = 30;

  // One table entry holds frame, value and slope side by side.
  localparam int ENTRY_W   = 96;

  // Divider operand and quotient widths.
  localparam int DIV_W     = 33;
  localparam int QUO_W     = UFRAC + 1;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [1:0] REG_OUT_MODE  = 2'd1;
  localparam logic [1:0] REG_MATCH_TOL = 2'd2;

  // Output formats.
  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_COLOR = 2'd2;

  // Transaction kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

endpackage

// ===== rtl/hermite_keyframe_evaluator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Hermite keyframe evaluator: sequencer, shared multiplier, APB registers.
// Depends on hkfe_pkg, hkfe_ram and hkfe_div.
//
// Channel   Direction  Handshake              Payload
// command   in         start & !busy          kind, key_slot, key_frame, key_value,
//                                             key_slope, query_frame
// result    out        done_o (one cycle)     curve_value_o, saturated_o
// config    in         psel&penable&pwrite    paddr, pwdata (prdata on reads)
//
// A key load is written to the table at its accept edge and leaves busy low.
// An evaluation keeps busy high from accept to the result: it reads the first key to clamp
// below it, then the last key to clamp above it, then runs a binary search of up to 6 probes
// and checks for a near-hit of a key frame; when blended it waits on the bit-serial
// divider, then makes 7 passes through the one 34x34 multiplier. The result strobe rises
// in the same cycle as busy falls.
// Reset clears the control state and the configuration registers; table contents stay undefined.
// The result strobe cannot be stalled.
module hermite_keyframe_evaluator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [5:0]          key_slot_i,
  input  logic signed [31:0]  key_frame_i,
  input  logic signed [31:0]  key_value_i,
  input  logic signed [31:0]  key_slope_i,
  input  logic signed [31:0]  query_frame_i,
  output logic                done_o,
  output logic signed [31:0]  curve_value_o,
  output logic                saturated_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hkfe_pkg::*;

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD0  = 5'd1;
  localparam logic [4:0] S_CHK0 = 5'd2;
  localparam logic [4:0] S_CHKN = 5'd3;
  localparam logic [4:0] S_PA   = 5'd4;
  localparam logic [4:0] S_PB   = 5'd5;
  localparam logic [4:0] S_RHI  = 5'd6;
  localparam logic [4:0] S_RNX  = 5'd7;
  localparam logic [4:0] S_RLO  = 5'd8;
  localparam logic [4:0] S_TOL  = 5'd9;
  localparam logic [4:0] S_DIV  = 5'd10;
  localparam logic [4:0] S_M1   = 5'd11;
  localparam logic [4:0] S_M2   = 5'd12;
  localparam logic [4:0] S_H    = 5'd13;
  localparam logic [4:0] S_M3   = 5'd14;
  localparam logic [4:0] S_M4   = 5'd15;
  localparam logic [4:0] S_M5   = 5'd16;
  localparam logic [4:0] S_M6   = 5'd17;
  localparam logic [4:0] S_T    = 5'd18;
  localparam logic [4:0] S_M7   = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;
  localparam logic [4:0] S_FMT  = 5'd21;

  localparam int MUL_W = 34;
  localparam int PRD_W = 2 * MUL_W;
  localparam int V_W   = 54;
  localparam int A_W   = PRD_W - UFRAC;

  // Configuration registers.
  logic [6:0]  key_count_q;
  logic [1:0]  out_mode_q;
  logic [15:0] match_tol_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= 7'd1;
      out_mode_q  <= MODE_RAW;
      match_tol_q <= 16'd66;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_KEY_COUNT: key_count_q <= pwdata[6:0];
        REG_OUT_MODE:  out_mode_q  <= pwdata[1:0];
        REG_MATCH_TOL: match_tol_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KEY_COUNT: prdata = {25'd0, key_count_q};
      REG_OUT_MODE:  prdata = {30'd0, out_mode_q};
      REG_MATCH_TOL: prdata = {16'd0, match_tol_q};
      default:       prdata = '0;
    endcase
  end

  // Index of the last key in use, after clamping the count to 1..MAX_KEYS.
  logic [KEY_AW-1:0] last_idx;
  always_comb begin
    if (key_count_q == 7'd0) begin
      last_idx = '0;
    end else if (key_count_q > 7'(MAX_KEYS)) begin
      last_idx = KEY_AW'(MAX_KEYS - 1);
    end else begin
      last_idx = KEY_AW'(key_count_q - 7'd1);
    end
  end

  // Key table.
  logic                accept;
  logic                ram_we;
  logic [KEY_AW-1:0]   addr_q, addr_d;
  logic [ENTRY_W-1:0]  rdata;
  logic signed [31:0]  rd_frame, rd_value, rd_slope;

  assign accept = start & ~busy;
  assign ram_we = accept & (kind_i == KIND_LOAD);

  hkfe_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KEYS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (key_slot_i[KEY_AW-1:0]),
    .wdata_i ({key_frame_i, key_value_i, key_slope_i}),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign rd_frame = rdata[95:64];
  assign rd_value = rdata[63:32];
  assign rd_slope = rdata[31:0];

  // Sequencer and datapath registers.
  logic [4:0]              state_q, state_d;
  logic signed [31:0]      q_q, q_d;
  logic [KEY_AW-1:0]       lo_q, lo_d, hi_q, hi_d;
  logic signed [31:0]      fhi_q, fhi_d, vhi_q, vhi_d, shi_q, shi_d;
  logic signed [31:0]      fnx_q, fnx_d, vnx_q, vnx_d;
  logic signed [31:0]      vlo_q, vlo_d, slo_q, slo_d;
  logic [DIV_W-1:0]        d_q, d_d;
  logic [QUO_W-1:0]        u_q, u_d, u2_q, u2_d;
  logic signed [MUL_W-1:0] h00_q, h00_d, h01_q, h01_d, h10_q, h10_d, h11_q, h11_d;
  logic signed [PRD_W-1:0] acc_q, acc_d, p_q;
  logic signed [A_W-1:0]   a_q, a_d;
  logic signed [MUL_W-1:0] tq_q, tq_d;
  logic signed [V_W-1:0]   v_q, v_d;
  logic                    done_q, done_d, sat_q, sat_d;
  logic signed [31:0]      res_q, res_d;

  // Shared multiplier with a registered product.
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PRD_W-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Divider.
  logic                div_start, div_done;
  logic [QUO_W-1:0]    div_quo;
  logic [DIV_W-1:0]    div_num;
  logic signed [32:0]  t_s, d_s, c_s, tol_s;

  hkfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (d_s[DIV_W-1:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Search helpers.
  logic [KEY_AW:0]     new_mid_sum;
  logic [KEY_AW-1:0]   new_lo, new_hi;
  logic signed [PRD_W-1:0] psum;
  logic signed [MUL_W-1:0] u3_s, u2_s, u_s;

  assign t_s     = 33'(q_q) - 33'(rd_frame);
  assign d_s     = 33'(fhi_q) - 33'(rd_frame);
  assign c_s     = 33'(q_q) - 33'(fhi_q);
  assign tol_s   = {17'd0, match_tol_q};
  assign div_num = t_s[DIV_W-1:0];
  assign psum    = acc_q + p_q;
  assign u3_s    = MUL_W'({1'b0, p_q[60:30]});
  assign u2_s    = MUL_W'({1'b0, u2_q});
  assign u_s     = MUL_W'({1'b0, u_q});

  always_comb begin
    new_lo      = lo_q;
    new_hi      = hi_q;
    if (q_q <= rd_frame) begin
      new_hi = addr_q;
    end else begin
      new_lo = addr_q;
    end
    new_mid_sum = {1'b0, new_lo} + {1'b0, new_hi};
  end

  // Output format conversion.
  logic signed [V_W:0] v_rnd;
  logic signed [V_W:0] r_s;
  logic signed [31:0]  fmt_val;
  logic                fmt_sat;

  always_comb begin
    v_rnd   = {v_q[V_W-1], v_q} + (V_W+1)'(32768);
    r_s     = v_rnd >>> FRAC_BITS;
    fmt_val = '0;
    fmt_sat = 1'b0;
    if (out_mode_q == MODE_BYTE) begin
      if (r_s < 0) begin
        fmt_sat = 1'b1;
      end else if (r_s > (V_W+1)'(255)) begin
        fmt_val = 32'sd255;
        fmt_sat = 1'b1;
      end else begin
        fmt_val = r_s[31:0];
      end
    end else if (out_mode_q == MODE_COLOR) begin
      if (r_s < -(V_W+1)'(1024)) begin
        fmt_val = -32'sd1024;
        fmt_sat = 1'b1;
      end else if (r_s > (V_W+1)'(1023)) begin
        fmt_val = 32'sd1023;
        fmt_sat = 1'b1;
      end else begin
        fmt_val = r_s[31:0];
      end
    end else begin
      if (v_q < -V_W'(64'sh80000000)) begin
        fmt_val = 32'sh80000000;
        fmt_sat = 1'b1;
      end else if (v_q > V_W'(64'sh7FFFFFFF)) begin
        fmt_val = 32'sh7FFFFFFF;
        fmt_sat = 1'b1;
      end else begin
        fmt_val = v_q[31:0];
      end
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    q_d       = q_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    fhi_d     = fhi_q;
    vhi_d     = vhi_q;
    shi_d     = shi_q;
    fnx_d     = fnx_q;
    vnx_d     = vnx_q;
    vlo_d     = vlo_q;
    slo_d     = slo_q;
    d_d       = d_q;
    u_d       = u_q;
    u2_d      = u2_q;
    h00_d     = h00_q;
    h01_d     = h01_q;
    h10_d     = h10_q;
    h11_d     = h11_q;
    acc_d     = acc_q;
    a_d       = a_q;
    tq_d      = tq_q;
    v_d       = v_q;
    done_d    = 1'b0;
    sat_d     = sat_q;
    res_d     = res_q;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && kind_i == KIND_EVAL) begin
          q_d     = query_frame_i;
          addr_d  = '0;
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        addr_d  = last_idx;
        state_d = S_CHK0;
      end
      S_CHK0: begin
        // First key: clamp below the curve.
        if (last_idx == '0 || q_q <= rd_frame) begin
          v_d     = V_W'(rd_value);
          state_d = S_FMT;
        end else begin
          state_d = S_CHKN;
        end
      end
      S_CHKN: begin
        // Last key: clamp above the curve, otherwise start the search (skipped for two keys).
        lo_d = '0;
        hi_d = last_idx;
        if (q_q >= rd_frame) begin
          v_d     = V_W'(rd_value);
          state_d = S_FMT;
        end else if (last_idx > KEY_AW'(1)) begin
          addr_d  = last_idx >> 1;
          state_d = S_PA;
        end else begin
          addr_d  = last_idx;
          state_d = S_RHI;
        end
      end
      S_PA: begin
        state_d = S_PB;
      end
      S_PB: begin
        // One probe of the binary search.
        lo_d = new_lo;
        hi_d = new_hi;
        if (new_hi - new_lo > KEY_AW'(1)) begin
          addr_d  = new_mid_sum[KEY_AW:1];
          state_d = S_PA;
        end else begin
          addr_d  = new_hi;
          state_d = S_RHI;
        end
      end
      S_RHI: begin
        addr_d  = hi_q + KEY_AW'(1);
        state_d = S_RNX;
      end
      S_RNX: begin
        fhi_d   = rd_frame;
        vhi_d   = rd_value;
        shi_d   = rd_slope;
        addr_d  = lo_q;
        state_d = S_RLO;
      end
      S_RLO: begin
        fnx_d   = rd_frame;
        vnx_d   = rd_value;
        state_d = S_TOL;
      end
      S_TOL: begin
        // Near-hit on the right key, else the left value if the span is empty, else divide.
        vlo_d = rd_value;
        slo_d = rd_slope;
        d_d   = d_s[DIV_W-1:0];
        if (c_s > -tol_s && c_s < tol_s) begin
          if (hi_q < last_idx && fhi_q == fnx_q) begin
            v_d = V_W'(vnx_q);
          end else begin
            v_d = V_W'(vhi_q);
          end
          state_d = S_FMT;
        end else if (d_s <= 0) begin
          v_d     = V_W'(rd_value);
          state_d = S_FMT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          u_d     = div_quo;
          state_d = S_M1;
        end
      end
      S_M1: begin
        mul_a   = u_s;
        mul_b   = u_s;
        state_d = S_M2;
      end
      S_M2: begin
        u2_d    = p_q[60:30];
        mul_a   = MUL_W'({1'b0, p_q[60:30]});
        mul_b   = u_s;
        state_d = S_H;
      end
      S_H: begin
        // Hermite basis weights in units of 2^-30.
        h00_d   = (u3_s <<< 1) - (u2_s + (u2_s <<< 1)) + (MUL_W'(1) <<< UFRAC);
        h01_d   = (u2_s + (u2_s <<< 1)) - (u3_s <<< 1);
        h10_d   = u3_s - (u2_s <<< 1) + u_s;
        h11_d   = u3_s - u2_s;
        state_d = S_M3;
      end
      S_M3: begin
        mul_a   = MUL_W'(vlo_q);
        mul_b   = h00_q;
        state_d = S_M4;
      end
      S_M4: begin
        acc_d   = p_q;
        mul_a   = MUL_W'(vhi_q);
        mul_b   = h01_q;
        state_d = S_M5;
      end
      S_M5: begin
        a_d     = psum[PRD_W-1:UFRAC];
        mul_a   = MUL_W'(slo_q);
        mul_b   = h10_q;
        state_d = S_M6;
      end
      S_M6: begin
        acc_d   = p_q;
        mul_a   = MUL_W'(shi_q);
        mul_b   = h11_q;
        state_d = S_T;
      end
      S_T: begin
        tq_d    = psum[UFRAC+MUL_W-1:UFRAC];
        state_d = S_M7;
      end
      S_M7: begin
        mul_a   = tq_q;
        mul_b   = MUL_W'({1'b0, d_q});
        state_d = S_FIN;
      end
      S_FIN: begin
        // The slope term is signed, so it is sign-extended before the add.
        v_d     = V_W'(a_q) + V_W'(signed'(p_q[PRD_W-1:FRAC_BITS]));
        state_d = S_FMT;
      end
      S_FMT: begin
        res_d   = fmt_val;
        sat_d   = fmt_sat;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    q_q    <= q_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    fhi_q  <= fhi_d;
    vhi_q  <= vhi_d;
    shi_q  <= shi_d;
    fnx_q  <= fnx_d;
    vnx_q  <= vnx_d;
    vlo_q  <= vlo_d;
    slo_q  <= slo_d;
    d_q    <= d_d;
    u_q    <= u_d;
    u2_q   <= u2_d;
    h00_q  <= h00_d;
    h01_q  <= h01_d;
    h10_q  <= h10_d;
    h11_q  <= h11_d;
    acc_q  <= acc_d;
    a_q    <= a_d;
    tq_q   <= tq_d;
    v_q    <= v_d;
    p_q    <= mul_p;
    res_q  <= res_d;
    sat_q  <= sat_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign curve_value_o = res_q;
  assign saturated_o   = sat_q;

`ifndef SYNTH
  // A result only follows an evaluation in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without a running evaluation");

  // Every evaluation ends with a result.
  a_fall_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("evaluation ended without a result");

  // The divider only finishes while the sequencer waits for it.
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider finished out of turn");
`endif

endmodule

// ===== rtl/hkfe_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module hkfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hkfe_div.sv =====
`timescale 1ns / 1ps
// Restoring divider producing floor(t * 2^30 / d) for 0 < t <= d.
// Depends on hkfe_pkg; one quotient bit per cycle.
module hkfe_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hkfe_pkg::DIV_W-1:0] num_i,
  input  logic [hkfe_pkg::DIV_W-1:0] den_i,
  output logic                      done_o,
  output logic [hkfe_pkg::QUO_W-1:0] quo_o
);
  import hkfe_pkg::*;

  localparam int CNT_W = $clog2(UFRAC + 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  den_q, den_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DIV_W:0]    shifted;
  logic              fits;

  // Load the operands on start; otherwise one restoring step: shift the remainder and try to subtract.
  always_comb begin
    shifted = {rem_q, 1'b0};
    fits    = shifted >= {1'b0, den_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      den_d = den_i;
      if (num_i >= den_i) begin
        rem_d = num_i - den_i;
        quo_d = QUO_W'(1);
      end else begin
        rem_d = num_i;
        quo_d = '0;
      end
    end else if (run_q) begin
      rem_d = fits ? DIV_W'(shifted - {1'b0, den_q}) : shifted[DIV_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(UFRAC - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
